// File: rtl/core/fbvt_pkg.sv
// Shared types and constants for the frustum box visibility test core.
// No dependencies.
package fbvt_pkg;

  localparam int NumPlanes  = 6;
  localparam int NumCorners = 8;

  localparam logic [1:0] ActLoadPlane  = 2'd0;
  localparam logic [1:0] ActLoadCorner = 2'd1;
  localparam logic [1:0] ActTestBox    = 2'd2;

  localparam logic [1:0] ReasonNone   = 2'd0;
  localparam logic [1:0] ReasonPlane  = 2'd1;
  localparam logic [1:0] ReasonCorner = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         slot;
    logic signed [31:0] load_a;
    logic signed [31:0] load_b;
    logic signed [31:0] load_c;
    logic signed [31:0] load_d;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } in_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] cull_reason;
  } out_t;

  // Test job handed from front to back.
  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               corner_cull;
  } job_t;

endpackage

// File: rtl/core/fbvt_front.sv
// Front end: accepts requests, holds frustum corners, runs the corner test,
// and forwards plane loads and test jobs. Depends on fbvt_pkg.
module fbvt_front (
  input  logic           clk,
  input  logic           rst,
  input  fbvt_pkg::in_t  req,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           plane_we,
  output logic [2:0]     plane_slot,
  output logic [127:0]   plane_data,
  output fbvt_pkg::job_t job,
  output logic           job_valid,
  input  logic           job_ready
);
  import fbvt_pkg::*;

  logic signed [31:0] cx [NumCorners];
  logic signed [31:0] cy [NumCorners];
  logic signed [31:0] cz [NumCorners];
  logic               acc;
  logic [7:0]         ax, bx, ay, by, az, bz;

  assign acc = req_valid && req_ready;
  assign req_ready = (req.action != ActTestBox) || job_ready;
  assign job_valid = req_valid && (req.action == ActTestBox);
  assign plane_we = acc && (req.action == ActLoadPlane) && (req.slot < 3'(NumPlanes));
  assign plane_slot = req.slot;
  assign plane_data = {req.load_a, req.load_b, req.load_c, req.load_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumCorners; k++) begin
        cx[k] <= '0;
        cy[k] <= '0;
        cz[k] <= '0;
      end
    end else if (acc && req.action == ActLoadCorner) begin
      cx[req.slot] <= req.load_a;
      cy[req.slot] <= req.load_b;
      cz[req.slot] <= req.load_c;
    end
  end

  always_comb begin
    for (int k = 0; k < NumCorners; k++) begin
      ax[k] = cx[k] > req.max_x;
      bx[k] = cx[k] < req.min_x;
      ay[k] = cy[k] > req.max_y;
      by[k] = cy[k] < req.min_y;
      az[k] = cz[k] > req.max_z;
      bz[k] = cz[k] < req.min_z;
    end
    job.min_x = req.min_x;
    job.min_y = req.min_y;
    job.min_z = req.min_z;
    job.max_x = req.max_x;
    job.max_y = req.max_y;
    job.max_z = req.max_z;
    job.corner_cull = (&ax) || (&bx) || (&ay) || (&by) || (&az) || (&bz);
  end
endmodule

// File: rtl/core/fbvt_queue.sv
// Two-entry queue of test jobs between front and back.
// Depends on fbvt_pkg.
module fbvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  fbvt_pkg::job_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output fbvt_pkg::job_t rd_data,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import fbvt_pkg::*;

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wptr] <= wr_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) wptr <= ~wptr;
      if (rd_valid && rd_ready) rptr <= ~rptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// File: rtl/core/fbvt_back.sv
// Back end: plane store and the plane test, one plane per cycle with eight
// box corner dot products in parallel. Depends on fbvt_pkg.
module fbvt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           plane_we,
  input  logic [2:0]     plane_slot,
  input  logic [127:0]   plane_data,
  input  fbvt_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_ready,
  output fbvt_pkg::out_t res,
  output logic           res_valid,
  input  logic           res_ready
);
  import fbvt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [127:0]       planes [NumPlanes];
  logic [1:0]         state;
  logic [2:0]         pidx;
  job_t               cur;
  logic               culled;
  logic signed [31:0] pa, pb, pc, pd;
  logic               all_neg;
  logic signed [63:0] prod_a [NumCorners];
  logic signed [63:0] prod_b [NumCorners];
  logic signed [63:0] prod_c [NumCorners];
  logic signed [65:0] sum [NumCorners];

  assign {pa, pb, pc, pd} = planes[pidx];
  assign job_ready = (state == StIdle);

  // Operands are sign-extended 32-bit values, so each product is 32x32.
  always_comb begin
    for (int k = 0; k < NumCorners; k++) begin
      prod_a[k] = 64'(pa) * 64'(k[0] ? cur.max_x : cur.min_x);
      prod_b[k] = 64'(pb) * 64'(k[1] ? cur.max_y : cur.min_y);
      prod_c[k] = 64'(pc) * 64'(k[2] ? cur.max_z : cur.min_z);
      sum[k] = 66'(prod_a[k]) + 66'(prod_b[k]) + 66'(prod_c[k]) + (66'(pd) <<< 16);
    end
    all_neg = 1'b1;
    for (int k = 0; k < NumCorners; k++) all_neg = all_neg && sum[k][65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NumPlanes; p++) planes[p] <= '0;
    end else if (plane_we) begin
      planes[plane_slot] <= plane_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      res_valid <= 1'b0;
      pidx <= '0;
      culled <= 1'b0;
    end else begin
      if (state == StDone && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (job_valid && job_ready) begin
            cur <= job;
            pidx <= '0;
            culled <= 1'b0;
            state <= StRun;
          end
        end
        StRun: begin
          if (all_neg) culled <= 1'b1;
          if (all_neg || pidx == 3'(NumPlanes - 1)) state <= StDone;
          else pidx <= pidx + 3'd1;
        end
        StDone: begin
          // Wait here only while the previous result is still unread.
          if (!res_valid || res_ready) begin
            if (culled) res <= '{visible: 1'b0, cull_reason: ReasonPlane};
            else if (cur.corner_cull) res <= '{visible: 1'b0, cull_reason: ReasonCorner};
            else res <= '{visible: 1'b1, cull_reason: ReasonNone};
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

// File: rtl/core/frustum_box_visibility_test_core.sv
// Top level of the frustum box visibility test core.
// Depends on fbvt_pkg, fbvt_front, fbvt_queue, fbvt_back.
//
// Load requests (planes, corners) give no result.
// A test request gives one result: the plane test walks the six planes, one
// per cycle, forming the eight box-corner dot products exactly, and stops at
// the first culling plane; the corner test is done in the front as the
// request is taken. In the back a test is taken in the idle state, walks up
// to six planes in the run state and posts its result in the done state;
// the result then sits in an output register, so the back can start the
// next test while it waits and only stalls in the done state when the
// previous result is still unread. A two-deep job queue lets the front keep
// taking corner loads and tests while the back works. Plane loads write the
// store at once, so a plane load is held at the input until no test is
// queued or running.
module frustum_box_visibility_test_core (
  input  logic            clk,
  input  logic            rst,
  input  fbvt_pkg::in_t   in_data,
  input  logic            in_valid,
  output logic            in_ready,
  output fbvt_pkg::out_t  out_data,
  output logic            out_valid,
  input  logic            out_ready
);
  import fbvt_pkg::*;

  logic         plane_we;
  logic [2:0]   plane_slot;
  logic [127:0] plane_data;
  job_t         fjob, qjob;
  logic         fvalid, fready, qvalid, qready;
  logic         busy;
  logic         qready_idle;

  // Hold plane loads while any test is pending so order is kept.
  logic         front_valid, front_ready;
  assign busy = qvalid || !qready_idle;
  assign front_valid = in_valid && !(in_data.action == ActLoadPlane && busy);
  assign in_ready = front_ready && !(in_data.action == ActLoadPlane && busy);

  fbvt_front u_front (
    .clk, .rst, .req(in_data), .req_valid(front_valid), .req_ready(front_ready),
    .plane_we, .plane_slot, .plane_data,
    .job(fjob), .job_valid(fvalid), .job_ready(fready)
  );

  fbvt_queue u_queue (
    .clk, .rst, .wr_data(fjob), .wr_valid(fvalid), .wr_ready(fready),
    .rd_data(qjob), .rd_valid(qvalid), .rd_ready(qready)
  );

  fbvt_back u_back (
    .clk, .rst, .plane_we, .plane_slot, .plane_data,
    .job(qjob), .job_valid(qvalid), .job_ready(qready),
    .res(out_data), .res_valid(out_valid), .res_ready(out_ready)
  );

  assign qready_idle = qready;
endmodule

// File: bench/tb_frustum_box_visibility_test_core.sv
// Self-checking testbench for frustum_box_visibility_test_core.
// Depends on fbvt_pkg and the core RTL; directed table then random requests,
// each result checked against a typed-in verdict or an exact in-bench cull predictor.
module tb_frustum_box_visibility_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fbvt_pkg::*;

  localparam int NumRandom   = 900;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;   // long receiver hold-off
  localparam int HoldAtCount = 120;   // results seen before the hold starts

  logic clk;
  logic rst;
  in_t  in_data;
  logic in_valid;
  logic in_ready;
  out_t out_data;
  logic out_valid;
  logic out_ready;

  frustum_box_visibility_test_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor state: plane p holds a,b,c,d at 4p..4p+3, corner k holds x,y,z at 3k..3k+2.
  logic signed [31:0] plane_mem [NumPlanes*4];
  logic signed [31:0] corner_mem [NumCorners*3];

  out_t verdicts_due [$];   // results still owed by the core
  int   mismatches;
  int   results_seen;
  int   cycles;
  bit   quiet;              // no random idling on either side while set

  // Directed table row: expected result typed in only where obvious.
  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } row_t;
  row_t directed [$];

  // Exact sign of a*x + b*y + c*z + d (all Q16.16), formed in 67 bits.
  function automatic bit plane_below(int p, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z);
    logic signed [66:0] sum;
    logic signed [66:0] ea, eb, ec, ed, ex, ey, ez;
    ea = plane_mem[4*p];   eb = plane_mem[4*p+1];
    ec = plane_mem[4*p+2]; ed = plane_mem[4*p+3];
    ex = x; ey = y; ez = z;
    sum = ea*ex + eb*ey + ec*ez + (ed <<< 16);
    return sum < 0;
  endfunction

  // Applies one request to the predictor state; returns 1 when it yields a result.
  function automatic bit cull_predict(in_t r, output out_t res);
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    logic signed [31:0] c;
    bit all_neg;
    int above, below;
    res = '0;
    if (r.action == ActLoadPlane) begin
      if (r.slot < NumPlanes) begin
        plane_mem[4*r.slot]   = r.load_a;
        plane_mem[4*r.slot+1] = r.load_b;
        plane_mem[4*r.slot+2] = r.load_c;
        plane_mem[4*r.slot+3] = r.load_d;
      end
      return 0;
    end
    if (r.action == ActLoadCorner) begin
      corner_mem[3*r.slot]   = r.load_a;
      corner_mem[3*r.slot+1] = r.load_b;
      corner_mem[3*r.slot+2] = r.load_c;
      return 0;
    end
    if (r.action != ActTestBox) return 0;
    bmin[0] = r.min_x; bmin[1] = r.min_y; bmin[2] = r.min_z;
    bmax[0] = r.max_x; bmax[1] = r.max_y; bmax[2] = r.max_z;
    for (int p = 0; p < NumPlanes; p++) begin
      all_neg = 1'b1;
      for (int k = 0; k < 8; k++)
        if (!plane_below(p, k[0] ? bmax[0] : bmin[0], k[1] ? bmax[1] : bmin[1],
                         k[2] ? bmax[2] : bmin[2]))
          all_neg = 1'b0;
      if (all_neg) begin
        res.visible = 1'b0;
        res.cull_reason = ReasonPlane;
        return 1;
      end
    end
    for (int ax = 0; ax < 3; ax++) begin
      above = 0;
      below = 0;
      for (int k = 0; k < NumCorners; k++) begin
        c = corner_mem[3*k+ax];
        if (c > bmax[ax]) above++;
        if (c < bmin[ax]) below++;
      end
      if (above == NumCorners || below == NumCorners) begin
        res.visible = 1'b0;
        res.cull_reason = ReasonCorner;
        return 1;
      end
    end
    res.visible = 1'b1;
    res.cull_reason = ReasonNone;
    return 1;
  endfunction

  // Q16.16 value: mostly small so culls happen, sometimes full range or extreme.
  function automatic logic [31:0] rand_fix();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    if (sel < 90) return $urandom;
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic in_t rand_req(logic [1:0] act, logic [2:0] slot);
    in_t r;
    r = '0;
    r.action = act;
    r.slot   = slot;
    r.load_a = rand_fix(); r.load_b = rand_fix();
    r.load_c = rand_fix(); r.load_d = rand_fix();
    r.min_x  = rand_fix(); r.min_y  = rand_fix(); r.min_z = rand_fix();
    // Box usually well formed and small; sometimes inverted or arbitrary.
    if ($urandom_range(9) < 8) begin
      r.max_x = r.min_x + $urandom_range(2 << 16);
      r.max_y = r.min_y + $urandom_range(2 << 16);
      r.max_z = r.min_z + $urandom_range(2 << 16);
    end else begin
      r.max_x = rand_fix(); r.max_y = rand_fix(); r.max_z = rand_fix();
    end
    return r;
  endfunction

  function automatic in_t box_req(logic [31:0] lo, logic [31:0] hi);
    in_t r;
    r = '0;
    r.action = ActTestBox;
    r.min_x = lo; r.min_y = lo; r.min_z = lo;
    r.max_x = hi; r.max_y = hi; r.max_z = hi;
    return r;
  endfunction

  function automatic in_t load_req(logic [1:0] act, logic [2:0] slot, logic [31:0] a,
                                   logic [31:0] b, logic [31:0] c, logic [31:0] d);
    in_t r;
    r = '0;
    r.action = act; r.slot = slot;
    r.load_a = a; r.load_b = b; r.load_c = c; r.load_d = d;
    return r;
  endfunction

  function automatic out_t verdict(logic vis, logic [1:0] why);
    out_t o;
    o.visible = vis;
    o.cull_reason = why;
    return o;
  endfunction

  // Drives one request and returns once it is taken. Plane loads wait for
  // every outstanding test to finish, with valid dropped meanwhile.
  task automatic send_req(in_t r, bit typed, out_t typed_res);
    out_t res;
    if (r.action == ActLoadPlane && verdicts_due.size() != 0) begin
      in_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clk);
    end
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (cull_predict(r, res))
      verdicts_due.push_back(typed ? typed_res : res);
  endtask

  // Result side: random stalls, one long hold-off, field-by-field compare.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_t want;
          want = verdicts_due.pop_front();
          if (out_data.visible !== want.visible || out_data.cull_reason !== want.cull_reason) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected visible=%0b reason=%0d, got visible=%0b reason=%0d",
                       want.visible, want.cull_reason, out_data.visible, out_data.cull_reason);
          end
        end
      end
      if (!hold_done && results_seen == HoldAtCount) begin
        hold_left = HoldCycles;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 11);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL frustum_box_visibility_test_core");
      $finish;
    end
  end

  initial begin
    logic [1:0] act;
    int sel;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    quiet = 0;
    in_valid = 1'b0;
    in_data = '0;
    foreach (plane_mem[i]) plane_mem[i] = '0;
    foreach (corner_mem[i]) corner_mem[i] = '0;

    // Directed rows: stores start zero, so a point box at the origin is seen,
    // a box off the origin is culled by the corners.
    directed.push_back('{box_req(32'h0, 32'h0), 1, verdict(1'b1, ReasonNone)});
    directed.push_back('{box_req(32'h0001_0000, 32'h0002_0000), 1,
                         verdict(1'b0, ReasonCorner)});
    directed.push_back('{box_req(32'h8000_0000, 32'h7fff_ffff), 1,
                         verdict(1'b1, ReasonNone)});
    // Inverted box tested as given: every corner lies beyond both x faces.
    directed.push_back('{box_req(32'h0001_0000, 32'hffff_0000), 1,
                         verdict(1'b0, ReasonCorner)});
    // Plane 3: x >= 0 kept; box with max_x < 0 is culled by the plane.
    directed.push_back('{load_req(ActLoadPlane, 3'd3, 32'h0001_0000, 0, 0, 0), 0, '0});
    directed.push_back('{box_req(32'hfffe_0000, 32'hffff_0000), 1,
                         verdict(1'b0, ReasonPlane)});
    // Out-of-range plane slots and the unused action are ignored.
    directed.push_back('{load_req(ActLoadPlane, 3'd6, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000), 0, '0});
    directed.push_back('{load_req(ActLoadPlane, 3'd7, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000), 0, '0});
    directed.push_back('{load_req(2'd3, 3'd0, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff, 32'hffff_ffff), 0, '0});
    directed.push_back('{box_req(32'h8000_0000, 32'h8000_0000), 0, '0});
    // Extreme coefficients and points: the wide sum must not wrap.
    directed.push_back('{load_req(ActLoadPlane, 3'd0, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000), 0, '0});
    directed.push_back('{load_req(ActLoadPlane, 3'd5, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000), 0, '0});
    directed.push_back('{box_req(32'h7fff_ffff, 32'h7fff_ffff), 0, '0});
    directed.push_back('{box_req(32'h8000_0000, 32'h8000_0000), 0, '0});
    directed.push_back('{box_req(32'hffff_ffff, 32'h0000_0000), 0, '0});
    // Corner loads at the extremes; load_d unused for corners.
    directed.push_back('{load_req(ActLoadCorner, 3'd0, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h7fff_ffff, 32'hffff_ffff), 0, '0});
    directed.push_back('{load_req(ActLoadCorner, 3'd7, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h0, 32'h0), 0, '0});
    directed.push_back('{box_req(32'h0, 32'h0001_0000), 0, '0});
    // Clear the wide planes again; a zero plane never culls, while d < 0 alone culls every box.
    directed.push_back('{load_req(ActLoadPlane, 3'd0, 0, 0, 0, 0), 0, '0});
    directed.push_back('{load_req(ActLoadPlane, 3'd5, 0, 0, 0, 32'hffff_0000), 0, '0});
    directed.push_back('{box_req(32'h0, 32'h0), 1, verdict(1'b0, ReasonPlane)});
    directed.push_back('{load_req(ActLoadPlane, 3'd5, 0, 0, 0, 0), 0, '0});
    directed.push_back('{box_req(32'h0, 32'h0), 0, '0});

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].res);

    // Random part: plane load groups, corner loads and tests mixed at random, with some noise.
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 400 && n < 550);
      sel = $urandom_range(99);
      if (sel < 6) begin
        repeat ($urandom_range(1, 6))
          send_req(rand_req(ActLoadPlane, 3'($urandom_range(NumPlanes - 1))), 0, '0);
      end else if (sel < 16) begin
        send_req(rand_req(ActLoadCorner, 3'($urandom_range(7))), 0, '0);
      end else if (sel < 20) begin
        // Noise: unused action or out-of-range plane slot.
        act = $urandom_range(1) ? 2'd3 : ActLoadPlane;
        send_req(rand_req(act, act == ActLoadPlane ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(7))), 0, '0);
      end else begin
        send_req(rand_req(ActTestBox, 3'($urandom_range(7))), 0, '0);
      end
    end
    in_valid <= 1'b0;
    quiet = 0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS frustum_box_visibility_test_core");
    end else begin
      $display("FAIL frustum_box_visibility_test_core");
    end
    $finish;
  end

endmodule
